// ----- hw/rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int TAG_W       = 8;
	localparam int PEND_W      = 5;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 16;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] expiry;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic              add;
		logic              pop;
		logic [TIME_W-1:0] when;
		logic [TAG_W-1:0]  tag;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/stq_cell.sv -----
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: keeps, takes the new entry, shifts in from
// the left neighbor on insert, or from the right neighbor on pop.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     left,
	input  logic       left_le,
	input  entry_t     right,
	output entry_t     cur,
	output logic       le
);

	logic              valid_q;
	logic [TIME_W-1:0] expiry_q;
	logic [TAG_W-1:0]  tag_q;
	entry_t            nxt;

	assign cur.valid  = valid_q;
	assign cur.expiry = expiry_q;
	assign cur.tag    = tag_q;
	// entry goes before the new one (ties stay ahead)
	assign le  = valid_q && (expiry_q <= ctrl.when);

	always_comb begin
		nxt = cur;
		if (ctrl.add) begin
			if (!le) begin
				if (left_le) begin
					nxt.valid  = 1'b1;
					nxt.expiry = ctrl.when;
					nxt.tag    = ctrl.tag;
				end else begin
					nxt = left;
				end
			end
		end else if (ctrl.pop) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		expiry_q <= nxt.expiry;
		tag_q    <= nxt.tag;
	end

endmodule

// ----- hw/rtl/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer queue held sorted by expiry in a chain of cells, with a time counter.
// ----------------------------------------------------------------------------
// Result: registered, valid on the master side in the cycle after a request is accepted.
// Throughput: one request per cycle while the master side is not stalled; every cell
// compares and shifts in the same cycle, and the head compare against now + 1 sets the tick path.
// Reset: arst_n clears the time, the count, all cell valid bits and the
// output valid; stored expiries and tags are not cleared.
module sorted_timer_queue import stq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // delay[31:0], tag[39:32]
	input  logic                  s_tuser,  // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // fired, fired_tag[8:1], dropped, pending[14:10], 0
);

	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              m_tvalid_q;
	logic              fired_q;
	logic [TAG_W-1:0]  fired_tag_q;
	logic              dropped_q;
	logic [PEND_W-1:0] pending_q;

	logic              accept;
	logic              is_add;
	logic              full;
	logic              do_add;
	logic              do_pop;
	logic [TIME_W-1:0] now_next;
	logic [TIME_W-1:0] delay;
	logic [TAG_W-1:0]  tag;
	cell_ctrl_t        ctrl;

	entry_t cells [QUEUE_DEPTH];
	logic   les   [QUEUE_DEPTH];

	assign delay    = s_tdata[TIME_W-1:0];
	assign tag      = s_tdata[TIME_W+TAG_W-1:TIME_W];
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_add   = (s_tuser == CMD_ADD);
	assign full     = cells[QUEUE_DEPTH-1].valid;
	assign now_next = now_q + 1'b1;
	assign do_add   = accept && is_add && !full;
	assign do_pop   = accept && !is_add && cells[0].valid && (cells[0].expiry <= now_next);

	assign ctrl.add  = do_add;
	assign ctrl.pop  = do_pop;
	assign ctrl.when = now_q + delay;
	assign ctrl.tag  = tag;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			logic   left_le;
			if (gi == 0) begin : g_first
				assign left_e  = '0;
				assign left_le = 1'b1;
			end else begin : g_mid
				assign left_e  = cells[gi-1];
				assign left_le = les[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = cells[gi+1];
			end
			stq_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.left    (left_e),
				.left_le (left_le),
				.right   (right_e),
				.cur     (cells[gi]),
				.le      (les[gi])
			);
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (do_add) begin
			count_nxt = count_q + 1'b1;
		end else if (do_pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept && !is_add) begin
				now_q <= now_next;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fired_q     <= do_pop;
			fired_tag_q <= do_pop ? cells[0].tag : '0;
			dropped_q   <= is_add && full;
			pending_q   <= PEND_W'(count_nxt);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, pending_q, dropped_q, fired_tag_q, fired_q};

endmodule

// ----- hw/rtl/stq_checker.sv -----
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the sorted timer queue result stream.
// ----------------------------------------------------------------------------
module stq_checker import stq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
		else $error("fired and dropped together");

	a_tag0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == '0))
		else $error("tag set without fire");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:10] <= PEND_W'(QUEUE_DEPTH)) || (QUEUE_DEPTH >= 32))
		else $error("pending above depth");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("request accepted without result");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
